// File: rtl/shet_pkg.sv
`timescale 1ns / 1ps

package shet_pkg;

    localparam int TAG_W    = 16;
    localparam int ENERGY_W = 32;
    localparam int SUM_W    = 40;
    localparam int FIELD_W  = 16;

    // per-entry payload carried alongside the key
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [SUM_W-1:0] sum;
    } shet_payload_t;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic add_en;      // an add transaction is applied this cycle
        logic ins_en;      // the key is new and there is room for it
        logic shift_down;  // readout: every cell takes its upper neighbor
    } shet_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } shet_state_t;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

// File: rtl/shet_cell.sv
`timescale 1ns / 1ps

module shet_cell
    import shet_pkg::*;
#(
    parameter int KEY_BITS = 48
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  shet_ctrl_t          ctrl,
    input  logic [KEY_BITS-1:0] new_key,
    input  shet_payload_t       new_pay,
    input  logic [ENERGY_W-1:0] new_energy,
    input  logic                prev_ge,
    input  logic                prev_valid,
    input  logic [KEY_BITS-1:0] prev_key,
    input  shet_payload_t       prev_pay,
    input  logic                next_valid,
    input  logic [KEY_BITS-1:0] next_key,
    input  shet_payload_t       next_pay,
    output logic                ge,
    output logic                eq,
    output logic                valid,
    output logic [KEY_BITS-1:0] key,
    output shet_payload_t       pay
);

    logic                valid_reg, valid_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    shet_payload_t       pay_reg, pay_next;
    logic [SUM_W:0]      acc;

    assign eq = valid_reg && (key_reg == new_key);
    // an empty cell sorts above every key
    assign ge = !valid_reg || (key_reg > new_key);

    assign acc = {1'b0, pay_reg.sum} + (SUM_W + 1)'(new_energy);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        pay_next   = pay_reg;
        if (ctrl.shift_down)
        begin
            valid_next = next_valid;
            key_next   = next_key;
            pay_next   = next_pay;
        end
        else if (ctrl.add_en)
        begin
            if (eq)
            begin
                pay_next.sum = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
            end
            else if (ctrl.ins_en && prev_ge)
            begin
                valid_next = prev_valid;
                key_next   = prev_key;
                pay_next   = prev_pay;
            end
            else if (ctrl.ins_en && ge)
            begin
                valid_next = 1'b1;
                key_next   = new_key;
                pay_next   = new_pay;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign pay   = pay_reg;

endmodule

// File: rtl/sorted_hit_energy_table.sv
`timescale 1ns / 1ps

// channel   dir  tdata (low bit up)                          tuser                  tlast
// s_axis    in   eta_index, phi_index, rho_index, hit_tag,   operation              -
//                energy (96 bits)
// m_axis    out  out_eta, out_phi, out_rho, out_tag,         entry_valid,           last
//                energy_sum (104 bits)                       overflowed
//
// adds are accepted back to back; every cell compares the new key at once
// and the chain opens a gap by one shift
// a readout gives one result per held entry (a single one for an empty
// table), the chain moving one cell toward the head per loaded result;
// the next input is accepted in the cycle after the last result is
// loaded into the output register
// output stalls hold the chain; reset clears only cell valid bits, the
// overflow flag, the state and the output valid, with no clearing pass

module sorted_hit_energy_table
    import shet_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_WIDTH   = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // eta_index, phi_index, rho_index, hit_tag, energy
    input  logic [0:0]    s_tuser,   // operation
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // out_eta, out_phi, out_rho, out_tag, energy_sum
    output logic [1:0]    m_tuser,   // entry_valid, overflowed
    output logic          m_tlast
);

    localparam int KEY_BITS = 3 * KEY_WIDTH;
    localparam int EXT_W    = (KEY_WIDTH > FIELD_W) ? KEY_WIDTH : FIELD_W;
    localparam logic [KEY_WIDTH-1:0] KEY_TOP = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    // input field split
    logic [FIELD_W-1:0]  in_field [3];
    logic [TAG_W-1:0]    in_tag;
    logic [ENERGY_W-1:0] in_energy;
    logic                in_op;

    assign in_field[0] = s_tdata[15:0];   // eta
    assign in_field[1] = s_tdata[31:16];  // phi
    assign in_field[2] = s_tdata[47:32];  // rho
    assign in_tag      = s_tdata[63:48];
    assign in_energy   = s_tdata[95:64];
    assign in_op       = s_tuser[0];

    // keys become offset binary so the composite compares unsigned
    logic [KEY_BITS-1:0] new_key;
    logic [KEY_BITS-1:0] head_key;
    logic [FIELD_W-1:0]  head_field [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_key
            logic signed [EXT_W-1:0]     ext;
            logic signed [KEY_WIDTH-1:0] dec;

            assign ext = EXT_W'(signed'(in_field[g]));
            // eta in the top slice, rho in the bottom one
            assign new_key[(2-g)*KEY_WIDTH +: KEY_WIDTH] = ext[KEY_WIDTH-1:0] ^ KEY_TOP;
            assign dec = signed'(head_key[(2-g)*KEY_WIDTH +: KEY_WIDTH] ^ KEY_TOP);
            assign head_field[g] = FIELD_W'(dec);
        end
    endgenerate

    // cell chain
    logic                valid_w [TABLE_DEPTH];
    logic                ge_w    [TABLE_DEPTH];
    logic                eq_w    [TABLE_DEPTH];
    logic [KEY_BITS-1:0] key_w   [TABLE_DEPTH];
    shet_payload_t       pay_w   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] eq_vec;

    shet_ctrl_t    ctrl;
    shet_payload_t new_pay;

    assign new_pay.tag = in_tag;
    assign new_pay.sum = SUM_W'(in_energy);

    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            logic                p_ge, p_valid, n_valid;
            logic [KEY_BITS-1:0] p_key, n_key;
            shet_payload_t       p_pay, n_pay;

            if (g == 0)
            begin : g_head
                assign p_ge    = 1'b0;
                assign p_valid = 1'b0;
                assign p_key   = '0;
                assign p_pay   = '0;
            end
            else
            begin : g_body
                assign p_ge    = ge_w[g-1];
                assign p_valid = valid_w[g-1];
                assign p_key   = key_w[g-1];
                assign p_pay   = pay_w[g-1];
            end

            if (g == TABLE_DEPTH - 1)
            begin : g_tail
                assign n_valid = 1'b0;
                assign n_key   = '0;
                assign n_pay   = '0;
            end
            else
            begin : g_mid
                assign n_valid = valid_w[g+1];
                assign n_key   = key_w[g+1];
                assign n_pay   = pay_w[g+1];
            end

            shet_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_key    (new_key),
                .new_pay    (new_pay),
                .new_energy (in_energy),
                .prev_ge    (p_ge),
                .prev_valid (p_valid),
                .prev_key   (p_key),
                .prev_pay   (p_pay),
                .next_valid (n_valid),
                .next_key   (n_key),
                .next_pay   (n_pay),
                .ge         (ge_w[g]),
                .eq         (eq_w[g]),
                .valid      (valid_w[g]),
                .key        (key_w[g]),
                .pay        (pay_w[g])
            );

            assign eq_vec[g] = eq_w[g];
        end
    endgenerate

    assign head_key = key_w[0];

    // control
    shet_state_t state_reg, state_next;
    logic        ovf_reg, ovf_next;
    logic        found, full, in_xact, add_xact, read_xact, load, load_last;

    assign found     = |eq_vec;
    assign full      = valid_w[TABLE_DEPTH-1];
    assign in_xact   = s_tvalid && s_tready;
    assign add_xact  = in_xact && (in_op == OP_ADD);
    assign read_xact = in_xact && (in_op == OP_READ);
    assign load      = (state_reg == ST_DRAIN) && (!m_tvalid || m_tready);
    // an empty head means an empty table: a single invalid result ends it
    assign load_last = !valid_w[0] || !valid_w[1];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (read_xact)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (load && load_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready        = 1'b0;
        ctrl.add_en     = 1'b0;
        ctrl.ins_en     = 1'b0;
        ctrl.shift_down = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                ctrl.add_en = add_xact;
                ctrl.ins_en = !found && !full;
            end
            ST_DRAIN:
            begin
                ctrl.shift_down = load;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // sticky drop flag, cleared once the readout's last result is loaded
    always_comb
    begin
        ovf_next = ovf_reg;
        if (add_xact && !found && full)
        begin
            ovf_next = 1'b1;
        end
        else if (load && load_last)
        begin
            ovf_next = 1'b0;
        end
    end

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [103:0]       out_data_reg;
    logic [1:0]         out_user_reg;
    logic               out_last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (valid_w[0])
            begin
                out_data_reg <= {pay_w[0].sum, pay_w[0].tag,
                                 head_field[2], head_field[1], head_field[0]};
            end
            else
            begin
                out_data_reg <= '0;
            end
            out_user_reg <= {ovf_reg, valid_w[0]};
            out_last_reg <= load_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/shet_checker.sv
`timescale 1ns / 1ps

module shet_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic [95:0]   s_tdata,
    input logic [0:0]    s_tuser,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [103:0]  m_tdata,
    input logic [1:0]    m_tuser,
    input logic          m_tlast
);

    // a stalled result keeps its place
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // an invalid result, as an empty readout gives, ends the readout
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("invalid result not marked last");

    // input closes while a readout runs
    a_read_block: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("input taken during readout");

    // a zeroed tdata accompanies an invalid result
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata == 104'd0))
        else $error("invalid result carries data");

endmodule

bind sorted_hit_energy_table shet_checker u_shet_checker (.*);
